### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/ttsp_pkg.sv
// Package: codes, constants and types of the temperature sensor poller.
`default_nettype none
package ttsp_pkg;

	localparam int NUM_SENSORS_DEF = 8;

	localparam logic [2:0] TOP_SENSOR_RST    = 3'd7;
	localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd30;
	localparam logic [7:0] TIMEOUT_SAT       = 8'hFF;

	localparam logic REG_TOP_SENSOR    = 1'b0;
	localparam logic REG_TIMEOUT_LIMIT = 1'b1;

	localparam logic ACT_POLL = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_STOP    = 2'd3;

	localparam logic [7:0] PH_REQ   = 8'h01;
	localparam logic [7:0] PH_DIR   = 8'h02;
	localparam logic [7:0] PH_START = 8'h04;
	localparam logic [7:0] PH_DATA  = 8'h08;
	localparam logic [7:0] PH_FIN   = 8'h10;
	localparam logic [7:0] PH_STOP  = 8'h20;
	localparam logic [7:0] PH_ADDR  = 8'h40;
	localparam logic [7:0] PH_ERR   = 8'h80;

	localparam logic [7:0] ADDR_WR_BASE   = 8'h90;
	localparam logic [7:0] ADDR_RD_BASE   = 8'h91;
	localparam logic [7:0] OP_START_CONV  = 8'hEE;
	localparam logic [7:0] OP_READ_TEMP   = 8'hAA;
	localparam logic [7:0] OP_READ_COUNT  = 8'hA8;
	localparam logic [7:0] OP_READ_SLOPE  = 8'hA9;

	localparam logic [7:0] STATUS_MASK  = 8'hF8;
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_RESTART   = 8'h10;
	localparam logic [7:0] ST_ADDR_W_OK = 8'h18;
	localparam logic [7:0] ST_ADDR_R_OK = 8'h40;

	localparam int TEMP_W = 13;

	typedef enum logic [2:0] {
		SEQ_IDLE      = 3'd0,
		SEQ_CONV      = 3'd1,
		SEQ_SEL_TEMP  = 3'd2,
		SEQ_RD_TEMP   = 3'd3,
		SEQ_SEL_COUNT = 3'd4,
		SEQ_RD_COUNT  = 3'd5,
		SEQ_SEL_SLOPE = 3'd6,
		SEQ_RD_SLOPE  = 3'd7
	} seq_step_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_DIV_A,
		CTL_DIV_B,
		CTL_EMIT
	} ctl_state_t;

endpackage
`default_nettype wire

### sv/ttsp_if.sv
// Channel interfaces: poll items, result items and configuration writes.
`default_nettype none
interface ttsp_poll_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic       step_done_flag;
	logic       stop_busy;
	logic [7:0] bus_status;
	logic [7:0] rx_byte;

	modport source (output valid, action, step_done_flag, stop_busy, bus_status, rx_byte,
		input ready);
	modport sink (input valid, action, step_done_flag, stop_busy, bus_status, rx_byte,
		output ready);
endinterface

interface ttsp_result_if;
	import ttsp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               bus_command;
	logic                     load_tx;
	logic [7:0]               tx_byte;
	logic                     temp_valid;
	logic signed [TEMP_W-1:0] temperature;
	logic [2:0]               sensor_index;
	logic                     divide_fault;
	logic                     round_done;

	modport source (output valid, bus_command, load_tx, tx_byte, temp_valid, temperature,
		sensor_index, divide_fault, round_done, input ready);
	modport sink (input valid, bus_command, load_tx, tx_byte, temp_valid, temperature,
		sensor_index, divide_fault, round_done, output ready);
endinterface

interface ttsp_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

### sv/twi_temp_sensor_poller.sv
// Top level: two-wire bus temperature sensor polling sequencer with serial divider.
// Each poll item carries the bus master's flags, status and received byte and gets
// exactly one result: the next bus command, an optional byte to load and, after the
// slope of a sensor has been read, its temperature in tenths of a degree (or a divide
// fault for a zero slope). Tick items only advance the timeout counter. An item is
// taken only while idle; its result is registered, then moved into the output
// register once that is empty or being read. The item that completes a sensor with
// a non-zero slope first passes through one radix-2 divider, which produces a
// quotient bit a cycle for the 16-bit slope division, and a reciprocal multiply that
// scales by one tenth. The block takes no item until the previous result has moved
// into the output register. Configuration writes are accepted in any cycle.
`default_nettype none
module twi_temp_sensor_poller #(
	parameter int NUM_SENSORS = ttsp_pkg::NUM_SENSORS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	ttsp_poll_if.sink     poll,
	ttsp_result_if.source result,
	ttsp_cfg_if.sink      cfg
);
	import ttsp_pkg::*;

	localparam logic [2:0]  LAST_SENSOR = 3'(NUM_SENSORS - 1);
	localparam logic [15:0] TENTH_RECIP = 16'd52429;
	localparam int          TENTH_SHIFT = 19;

	function automatic logic [7:0] addr_byte(input logic rd, input logic [2:0] s);
		return (rd ? ADDR_RD_BASE : ADDR_WR_BASE) | {4'b0000, s, 1'b0};
	endfunction

	logic [2:0] top_q;
	logic [7:0] limit_q;

	seq_step_t  step_q, step_n;
	logic [7:0] phase_q, phase_n;
	logic [7:0] tcount_q, tcount_n;
	logic [7:0] addr_q, addr_n;
	logic [7:0] data_q, data_n;
	logic [2:0] sensor_q, sensor_n;
	logic [7:0] whole_q, whole_n;
	logic [7:0] remain_q, remain_n;

	logic [1:0] cmd_n;
	logic       load_n;
	logic [7:0] tx_n;
	logic       tvalid_n;
	logic [2:0] idx_n;
	logic       fault_n;
	logic       wrap_n;
	logic       need_div;

	logic [7:0] status;
	logic [2:0] top_eff;

	ctl_state_t state_q, state_n;
	logic       acc;
	logic       emit;
	logic       dv_load_b;

	logic [1:0]               res_cmd_q;
	logic                     res_load_q;
	logic [7:0]               res_tx_q;
	logic                     res_tvalid_q;
	logic signed [TEMP_W-1:0] res_temp_q;
	logic [2:0]               res_idx_q;
	logic                     res_fault_q;
	logic                     res_wrap_q;

	logic                     out_valid_q;
	logic [1:0]               out_cmd_q;
	logic                     out_load_q;
	logic [7:0]               out_tx_q;
	logic                     out_tvalid_q;
	logic signed [TEMP_W-1:0] out_temp_q;
	logic [2:0]               out_idx_q;
	logic                     out_fault_q;
	logic                     out_wrap_q;

	logic [7:0]  dv_rem_q, dv_div_q;
	logic [15:0] dv_quo_q;
	logic [3:0]  dv_cnt_q;
	logic        dv_neg_q;
	logic [8:0]  dv_shift;
	logic        dv_ge;
	logic [7:0]  dv_rem_nx;
	logic [15:0] dv_quo_nx;
	logic        dv_last;
	logic [31:0] dv_prod;

	logic signed [9:0]  diff_a;
	logic signed [16:0] num_a;
	logic [15:0]        mag_a;
	logic signed [17:0] frac_x;
	logic signed [17:0] whole_x;
	logic signed [17:0] num_b;
	logic [15:0]        mag_b;
	logic [TEMP_W-1:0]  quo_t;

	assign status  = poll.bus_status & STATUS_MASK;
	assign top_eff = (top_q > LAST_SENSOR) ? LAST_SENSOR : top_q;

	always_comb begin
		step_n   = step_q;
		phase_n  = phase_q;
		tcount_n = tcount_q;
		addr_n   = addr_q;
		data_n   = data_q;
		sensor_n = sensor_q;
		whole_n  = whole_q;
		remain_n = remain_q;
		cmd_n    = CMD_NONE;
		load_n   = 1'b0;
		tx_n     = 8'h00;
		tvalid_n = 1'b0;
		idx_n    = 3'd0;
		fault_n  = 1'b0;
		wrap_n   = 1'b0;
		need_div = 1'b0;
		if (poll.action == ACT_TICK) begin
			if (tcount_q != 8'h00 && tcount_q != TIMEOUT_SAT) begin
				tcount_n = tcount_q + 8'd1;
			end
		end else begin
			if (phase_q != 8'h00) begin
				if ((phase_q & ~PH_DIR) == PH_REQ) begin
					phase_n  = phase_q | PH_START;
					tcount_n = 8'd1;
					cmd_n    = CMD_START;
				end else if ((phase_q & PH_START) != 8'h00 && poll.step_done_flag) begin
					if (status != ST_START && status != ST_RESTART) begin
						phase_n = PH_ERR | PH_STOP;
						cmd_n   = CMD_STOP;
					end else begin
						phase_n  = (phase_q & ~PH_START) | PH_ADDR;
						load_n   = 1'b1;
						tx_n     = addr_q;
						tcount_n = 8'd1;
						cmd_n    = CMD_RELEASE;
					end
				end else if ((phase_q & PH_ADDR) != 8'h00 && poll.step_done_flag) begin
					if (status != ST_ADDR_W_OK && status != ST_ADDR_R_OK) begin
						phase_n = PH_ERR | PH_STOP;
						cmd_n   = CMD_STOP;
					end else begin
						phase_n  = (phase_q & ~PH_ADDR) | PH_DATA;
						tcount_n = 8'd1;
						if ((phase_q & PH_DIR) == 8'h00) begin
							load_n = 1'b1;
							tx_n   = data_q;
						end
						cmd_n = CMD_RELEASE;
					end
				end else if ((phase_q & PH_DATA) != 8'h00 && poll.step_done_flag) begin
					if ((phase_q & PH_DIR) != 8'h00) begin
						data_n = poll.rx_byte;
					end
					phase_n  = (phase_q & ~PH_DATA) | PH_STOP;
					tcount_n = 8'd1;
					cmd_n    = CMD_STOP;
				end else if ((phase_q & PH_STOP) != 8'h00 && !poll.stop_busy) begin
					tcount_n = 8'd0;
					if ((phase_q & PH_ERR) == 8'h00) begin
						phase_n = PH_FIN;
					end else begin
						phase_n = phase_q & ~PH_STOP;
					end
				end else if ((phase_q & ~(PH_FIN | PH_ERR)) != 8'h00 && tcount_q > limit_q) begin
					phase_n = PH_ERR | PH_STOP;
					cmd_n   = CMD_STOP;
				end
			end
			if (step_q == SEQ_IDLE) begin
				data_n  = OP_START_CONV;
				addr_n  = addr_byte(1'b0, sensor_q);
				phase_n = PH_REQ;
				step_n  = SEQ_CONV;
			end else if ((phase_n & (PH_FIN | PH_ERR)) != 8'h00) begin
				case (step_q)
					SEQ_CONV: begin
						data_n  = OP_READ_TEMP;
						addr_n  = addr_byte(1'b0, sensor_q);
						phase_n = PH_REQ;
						step_n  = SEQ_SEL_TEMP;
					end
					SEQ_SEL_TEMP: begin
						addr_n  = addr_byte(1'b1, sensor_q);
						phase_n = PH_REQ | PH_DIR;
						step_n  = SEQ_RD_TEMP;
					end
					SEQ_RD_TEMP: begin
						whole_n = data_n;
						data_n  = OP_READ_COUNT;
						addr_n  = addr_byte(1'b0, sensor_q);
						phase_n = PH_REQ;
						step_n  = SEQ_SEL_COUNT;
					end
					SEQ_SEL_COUNT: begin
						addr_n  = addr_byte(1'b1, sensor_q);
						phase_n = PH_REQ | PH_DIR;
						step_n  = SEQ_RD_COUNT;
					end
					SEQ_RD_COUNT: begin
						remain_n = data_n;
						data_n   = OP_READ_SLOPE;
						addr_n   = addr_byte(1'b0, sensor_q);
						phase_n  = PH_REQ;
						step_n   = SEQ_SEL_SLOPE;
					end
					SEQ_SEL_SLOPE: begin
						addr_n  = addr_byte(1'b1, sensor_q);
						phase_n = PH_REQ | PH_DIR;
						step_n  = SEQ_RD_SLOPE;
					end
					SEQ_RD_SLOPE: begin
						tvalid_n = 1'b1;
						idx_n    = sensor_q;
						if (data_n == 8'h00) begin
							fault_n = 1'b1;
						end else begin
							need_div = 1'b1;
						end
						phase_n = 8'h00;
						step_n  = SEQ_IDLE;
						if (({1'b0, sensor_q} + 4'd1) > {1'b0, top_eff}) begin
							sensor_n = 3'd0;
							wrap_n   = 1'b1;
						end else begin
							sensor_n = sensor_q + 3'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		poll.ready = 1'b0;
		acc        = 1'b0;
		emit       = 1'b0;
		dv_load_b  = 1'b0;
		case (state_q)
			CTL_IDLE: begin
				poll.ready = 1'b1;
				acc        = poll.valid;
				if (poll.valid) begin
					state_n = need_div ? CTL_DIV_A : CTL_EMIT;
				end
			end
			CTL_DIV_A: begin
				if (dv_last) begin
					dv_load_b = 1'b1;
					state_n   = CTL_DIV_B;
				end
			end
			CTL_DIV_B: begin
				state_n = CTL_EMIT;
			end
			CTL_EMIT: begin
				emit = !out_valid_q || result.ready;
				if (emit) begin
					state_n = CTL_IDLE;
				end
			end
			default: begin
				state_n = CTL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= TOP_SENSOR_RST;
			limit_q <= TIMEOUT_LIMIT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_TOP_SENSOR) begin
				top_q <= cfg.wdata[2:0];
			end else begin
				limit_q <= cfg.wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= SEQ_IDLE;
			phase_q  <= 8'h00;
			tcount_q <= 8'h00;
			addr_q   <= 8'h00;
			data_q   <= 8'h00;
			sensor_q <= 3'd0;
			whole_q  <= 8'h00;
			remain_q <= 8'h00;
		end else if (acc) begin
			step_q   <= step_n;
			phase_q  <= phase_n;
			tcount_q <= tcount_n;
			addr_q   <= addr_n;
			data_q   <= data_n;
			sensor_q <= sensor_n;
			whole_q  <= whole_n;
			remain_q <= remain_n;
		end
	end

	assign dv_shift  = {dv_rem_q, dv_quo_q[15]};
	assign dv_ge     = dv_shift >= {1'b0, dv_div_q};
	assign dv_rem_nx = dv_ge ? 8'(dv_shift - {1'b0, dv_div_q}) : dv_shift[7:0];
	assign dv_quo_nx = {dv_quo_q[14:0], dv_ge};
	assign dv_last   = dv_cnt_q == 4'hF;

	assign diff_a = $signed({2'b00, data_n}) - $signed({2'b00, remain_q});
	assign num_a  = 17'(diff_a) * 17'sd100;
	assign mag_a  = num_a[16] ? 16'(-num_a) : num_a[15:0];

	assign frac_x  = dv_neg_q ? -$signed({2'b00, dv_quo_nx}) : $signed({2'b00, dv_quo_nx});
	assign whole_x = 18'($signed(whole_q));
	assign num_b   = whole_x * 18'sd100 - 18'sd25 + frac_x;
	assign mag_b   = num_b[17] ? 16'(-num_b) : num_b[15:0];

	assign dv_prod = {16'h0000, dv_quo_q} * {16'h0000, TENTH_RECIP};
	assign quo_t   = dv_prod[TENTH_SHIFT +: TEMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_cnt_q <= 4'd0;
		end else if (acc || dv_load_b) begin
			dv_cnt_q <= 4'd0;
		end else if (state_q == CTL_DIV_A) begin
			dv_cnt_q <= dv_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && need_div) begin
			dv_rem_q <= 8'h00;
			dv_quo_q <= mag_a;
			dv_div_q <= data_n;
			dv_neg_q <= num_a[16];
		end else if (dv_load_b) begin
			dv_quo_q <= mag_b;
			dv_neg_q <= num_b[17];
		end else if (state_q == CTL_DIV_A) begin
			dv_rem_q <= dv_rem_nx;
			dv_quo_q <= dv_quo_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_cmd_q    <= cmd_n;
			res_load_q   <= load_n;
			res_tx_q     <= tx_n;
			res_tvalid_q <= tvalid_n;
			res_temp_q   <= '0;
			res_idx_q    <= idx_n;
			res_fault_q  <= fault_n;
			res_wrap_q   <= wrap_n;
		end else if (state_q == CTL_DIV_B) begin
			res_temp_q <= dv_neg_q ? -$signed(quo_t) : $signed(quo_t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_cmd_q    <= res_cmd_q;
			out_load_q   <= res_load_q;
			out_tx_q     <= res_tx_q;
			out_tvalid_q <= res_tvalid_q;
			out_temp_q   <= res_temp_q;
			out_idx_q    <= res_idx_q;
			out_fault_q  <= res_fault_q;
			out_wrap_q   <= res_wrap_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.bus_command  = out_cmd_q;
	assign result.load_tx      = out_load_q;
	assign result.tx_byte      = out_tx_q;
	assign result.temp_valid   = out_tvalid_q;
	assign result.temperature  = out_temp_q;
	assign result.sensor_index = out_idx_q;
	assign result.divide_fault = out_fault_q;
	assign result.round_done   = out_wrap_q;

endmodule
`default_nettype wire

### sv/ttsp_checker.sv
// Port checker for the temperature sensor poller and its bind.
`default_nettype none
`include "assert_macros.svh"
module ttsp_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              out_valid,
	input wire              out_ready,
	input wire              load_tx,
	input wire [7:0]        tx_byte,
	input wire              temp_valid,
	input wire signed [12:0] temperature,
	input wire [2:0]        sensor_index,
	input wire              divide_fault,
	input wire              round_done
);
	`ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)
	`ASSERT_IMPL(a_tx_idle_zero, out_valid && !load_tx, tx_byte == 8'h00)
	`ASSERT_IMPL(a_no_temp_zero, out_valid && !temp_valid, temperature == 13'sd0 && sensor_index == 3'd0 && !divide_fault && !round_done)
	`ASSERT_IMPL(a_fault_zero, out_valid && divide_fault, temp_valid && temperature == 13'sd0)
	`ASSERT_IMPL(a_temp_range, out_valid && temp_valid, temperature >= -13'sd3822 && temperature <= 13'sd1277)
endmodule

bind twi_temp_sensor_poller ttsp_checker u_ttsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.load_tx      (result.load_tx),
	.tx_byte      (result.tx_byte),
	.temp_valid   (result.temp_valid),
	.temperature  (result.temperature),
	.sensor_index (result.sensor_index),
	.divide_fault (result.divide_fault),
	.round_done   (result.round_done)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for the temperature sensor poller: queued poll items, a bit-exact predictor, checked replies.
module tb;
	import ttsp_pkg::*;

	localparam int SENSORS = NUM_SENSORS_DEF;

	typedef struct packed {
		logic       action;
		logic       done;
		logic       busy;
		logic [7:0] status;
		logic [7:0] rx;
	} poll_item_t;

	typedef struct packed {
		logic [1:0]               cmd;
		logic                     load;
		logic [7:0]               tx;
		logic                     tvalid;
		logic signed [TEMP_W-1:0] temp;
		logic [2:0]               idx;
		logic                     fault;
		logic                     wrap;
	} bus_reply_t;

	typedef struct packed {
		logic       index;
		logic [7:0] value;
	} reg_write_t;

	logic clk;
	logic arst_n;

	ttsp_poll_if   poll_bus();
	ttsp_result_if result_bus();
	ttsp_cfg_if    cfg_bus();

	twi_temp_sensor_poller #(.NUM_SENSORS(SENSORS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	poll_item_t pending_polls[$];
	reg_write_t pending_writes[$];
	bus_reply_t expected_replies[$];

	poll_item_t poll_cur;
	reg_write_t write_cur;
	bus_reply_t reply_pred;
	bus_reply_t reply_want;

	int  mismatches;
	int  polls_queued;
	int  send_gap;
	int  stall_left;
	int  noise_pct;
	bit  idle_on;

	logic [2:0]  top_sensor;
	logic [7:0]  timeout_limit;
	seq_step_t   seq_step;
	logic [7:0]  bus_phase;
	logic [7:0]  tick_count;
	logic [7:0]  addr_byte;
	logic [7:0]  data_byte;
	logic [2:0]  sensor;
	logic [7:0]  whole_byte;
	logic [7:0]  remain_byte;

	logic [7:0]  top_plan [0:7];
	logic [7:0]  limit_plan [0:7];

	function automatic logic rbit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] rbyte();
		return 8'($urandom);
	endfunction

	function automatic int next_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void open_xfer(input bit rd);
		addr_byte = (rd ? ADDR_RD_BASE : ADDR_WR_BASE) | {4'b0000, sensor, 1'b0};
		bus_phase = rd ? (PH_REQ | PH_DIR) : PH_REQ;
	endfunction

	function automatic void predict_reply(input poll_item_t it, output bus_reply_t r);
		logic [7:0] st;
		logic [2:0] last;
		bit         abort;
		int         slope;
		int         whole;
		int         frac;
		int         tenths;
		r = '0;
		abort = 1'b0;
		st = it.status & STATUS_MASK;
		if (it.action == ACT_TICK) begin
			if (tick_count > 8'd0 && tick_count < TIMEOUT_SAT)
				tick_count = tick_count + 8'd1;
			return;
		end
		if (bus_phase != 8'h00) begin
			if ((bus_phase & ~PH_DIR) == PH_REQ) begin
				bus_phase = bus_phase | PH_START;
				tick_count = 8'd1;
				r.cmd = CMD_START;
			end else if (|(bus_phase & PH_START) && it.done) begin
				if (st != ST_START && st != ST_RESTART) begin
					abort = 1'b1;
				end else begin
					bus_phase = (bus_phase & ~PH_START) | PH_ADDR;
					r.load = 1'b1;
					r.tx = addr_byte;
					tick_count = 8'd1;
					r.cmd = CMD_RELEASE;
				end
			end else if (|(bus_phase & PH_ADDR) && it.done) begin
				if (st != ST_ADDR_W_OK && st != ST_ADDR_R_OK) begin
					abort = 1'b1;
				end else begin
					bus_phase = (bus_phase & ~PH_ADDR) | PH_DATA;
					tick_count = 8'd1;
					if (!(|(bus_phase & PH_DIR))) begin
						r.load = 1'b1;
						r.tx = data_byte;
					end
					r.cmd = CMD_RELEASE;
				end
			end else if (|(bus_phase & PH_DATA) && it.done) begin
				bus_phase = bus_phase & ~PH_DATA;
				if (|(bus_phase & PH_DIR))
					data_byte = it.rx;
				bus_phase = bus_phase | PH_STOP;
				tick_count = 8'd1;
				r.cmd = CMD_STOP;
			end else if (|(bus_phase & PH_STOP) && !it.busy) begin
				tick_count = 8'd0;
				if (!(|(bus_phase & PH_ERR)))
					bus_phase = PH_FIN;
				else
					bus_phase = bus_phase & ~PH_STOP;
			end else if (|(bus_phase & ~(PH_FIN | PH_ERR)) && tick_count > timeout_limit) begin
				abort = 1'b1;
			end
			if (abort) begin
				bus_phase = PH_ERR | PH_STOP;
				r.cmd = CMD_STOP;
			end
		end
		if (seq_step == SEQ_IDLE) begin
			data_byte = OP_START_CONV;
			open_xfer(1'b0);
			seq_step = SEQ_CONV;
		end else if (|(bus_phase & (PH_FIN | PH_ERR))) begin
			case (seq_step)
				SEQ_CONV: begin
					data_byte = OP_READ_TEMP;
					open_xfer(1'b0);
					seq_step = SEQ_SEL_TEMP;
				end
				SEQ_SEL_TEMP: begin
					open_xfer(1'b1);
					seq_step = SEQ_RD_TEMP;
				end
				SEQ_RD_TEMP: begin
					whole_byte = data_byte;
					data_byte = OP_READ_COUNT;
					open_xfer(1'b0);
					seq_step = SEQ_SEL_COUNT;
				end
				SEQ_SEL_COUNT: begin
					open_xfer(1'b1);
					seq_step = SEQ_RD_COUNT;
				end
				SEQ_RD_COUNT: begin
					remain_byte = data_byte;
					data_byte = OP_READ_SLOPE;
					open_xfer(1'b0);
					seq_step = SEQ_SEL_SLOPE;
				end
				SEQ_SEL_SLOPE: begin
					open_xfer(1'b1);
					seq_step = SEQ_RD_SLOPE;
				end
				default: begin
					slope = data_byte;
					whole = $signed(whole_byte);
					r.tvalid = 1'b1;
					r.idx = sensor;
					if (slope == 0) begin
						r.fault = 1'b1;
					end else begin
						frac = (slope * 100 - int'(remain_byte) * 100) / slope;
						tenths = (whole * 100 - 25 + frac) / 10;
						r.temp = tenths[TEMP_W-1:0];
					end
					bus_phase = 8'h00;
					seq_step = SEQ_IDLE;
					last = top_sensor;
					if (int'(last) > SENSORS - 1)
						last = 3'(SENSORS - 1);
					if (int'(sensor) + 1 > int'(last)) begin
						sensor = 3'd0;
						r.wrap = 1'b1;
					end else begin
						sensor = sensor + 3'd1;
					end
				end
			endcase
		end
	endfunction

	function automatic void compare_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic push_poll(input logic action, input logic done, input logic busy,
		input logic [7:0] status, input logic [7:0] rx);
		poll_item_t it;
		it.action = action;
		it.done = done;
		it.busy = busy;
		it.status = status;
		it.rx = rx;
		pending_polls.push_back(it);
		polls_queued++;
	endtask

	function automatic logic [7:0] pick_status(input bit ok, input bit addr_stage);
		logic [7:0] s;
		logic [7:0] m;
		if (ok) begin
			if (addr_stage)
				s = rbit() ? ST_ADDR_W_OK : ST_ADDR_R_OK;
			else
				s = rbit() ? ST_START : ST_RESTART;
			s[2:0] = 3'($urandom_range(0, 7));
			return s;
		end
		do begin
			s = rbyte();
			m = s & STATUS_MASK;
		end while (addr_stage ? (m == ST_ADDR_W_OK || m == ST_ADDR_R_OK)
			: (m == ST_START || m == ST_RESTART));
		return s;
	endfunction

	task automatic add_noise(input bit in_stop);
		int n;
		if ($urandom_range(0, 99) < noise_pct) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				if (rbit())
					push_poll(ACT_TICK, rbit(), rbit(), rbyte(), rbyte());
				else if (in_stop)
					push_poll(ACT_POLL, rbit(), 1'b1, rbyte(), rbyte());
				else
					push_poll(ACT_POLL, 1'b0, rbit(), rbyte(), rbyte());
			end
		end
		if ($urandom_range(0, 149) == 0) begin
			n = $urandom_range(20, 40);
			repeat (n) push_poll(ACT_TICK, rbit(), rbit(), rbyte(), rbyte());
		end
	endtask

	task automatic bus_xfer(input logic [7:0] rx);
		int mode;
		mode = $urandom_range(0, 99);
		push_poll(ACT_POLL, rbit(), rbit(), rbyte(), rbyte());
		add_noise(1'b0);
		push_poll(ACT_POLL, 1'b1, rbit(), pick_status(mode >= 6, 1'b0), rbyte());
		if (mode >= 6) begin
			add_noise(1'b0);
			push_poll(ACT_POLL, 1'b1, rbit(), pick_status(mode >= 12, 1'b1), rbyte());
			if (mode >= 12) begin
				add_noise(1'b0);
				push_poll(ACT_POLL, 1'b1, rbit(), rbyte(), rx);
			end
		end
		add_noise(1'b1);
		push_poll(ACT_POLL, rbit(), 1'b0, rbyte(), rbyte());
	endtask

	task automatic poll_sensor();
		logic [7:0] slope;
		slope = ($urandom_range(0, 7) == 0) ? 8'h00 : rbyte();
		push_poll(ACT_POLL, rbit(), rbit(), rbyte(), rbyte());
		bus_xfer(rbyte());
		bus_xfer(rbyte());
		bus_xfer(rbyte());
		bus_xfer(rbyte());
		bus_xfer(rbyte());
		bus_xfer(rbyte());
		bus_xfer(slope);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_polls.size() != 0 || poll_bus.valid || expected_replies.size() != 0);
	endtask

	task automatic write_reg(input logic index, input logic [7:0] value);
		reg_write_t w;
		w.index = index;
		w.value = value;
		pending_writes.push_back(w);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		poll_bus.valid = 1'b0;
		poll_bus.action = ACT_POLL;
		poll_bus.step_done_flag = 1'b0;
		poll_bus.stop_busy = 1'b0;
		poll_bus.bus_status = 8'h00;
		poll_bus.rx_byte = 8'h00;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_TOP_SENSOR;
		cfg_bus.wdata = 8'h00;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("tb failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_bus.valid <= 1'b0;
			poll_bus.action <= ACT_POLL;
			poll_bus.step_done_flag <= 1'b0;
			poll_bus.stop_busy <= 1'b0;
			poll_bus.bus_status <= 8'h00;
			poll_bus.rx_byte <= 8'h00;
			send_gap = 0;
			seq_step = SEQ_IDLE;
			bus_phase = 8'h00;
			tick_count = 8'd0;
			addr_byte = 8'h00;
			data_byte = 8'h00;
			sensor = 3'd0;
			whole_byte = 8'h00;
			remain_byte = 8'h00;
		end else begin
			if (poll_bus.valid && poll_bus.ready) begin
				predict_reply(poll_cur, reply_pred);
				expected_replies.push_back(reply_pred);
			end
			if (!poll_bus.valid || poll_bus.ready) begin
				if (send_gap > 0 || pending_polls.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					poll_bus.valid <= 1'b0;
				end else begin
					poll_cur = pending_polls.pop_front();
					poll_bus.valid <= 1'b1;
					poll_bus.action <= poll_cur.action;
					poll_bus.step_done_flag <= poll_cur.done;
					poll_bus.stop_busy <= poll_cur.busy;
					poll_bus.bus_status <= poll_cur.status;
					poll_bus.rx_byte <= poll_cur.rx;
					send_gap = next_gap();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bus.valid <= 1'b0;
			cfg_bus.index <= REG_TOP_SENSOR;
			cfg_bus.wdata <= 8'h00;
			top_sensor = TOP_SENSOR_RST;
			timeout_limit = TIMEOUT_LIMIT_RST;
		end else begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				if (write_cur.index == REG_TOP_SENSOR)
					top_sensor = write_cur.value[2:0];
				else
					timeout_limit = write_cur.value;
			end
			if (!cfg_bus.valid || cfg_bus.ready) begin
				if (pending_writes.size() == 0) begin
					cfg_bus.valid <= 1'b0;
				end else begin
					write_cur = pending_writes.pop_front();
					cfg_bus.valid <= 1'b1;
					cfg_bus.index <= write_cur.index;
					cfg_bus.wdata <= write_cur.value;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply with no poll item outstanding");
					mismatches++;
				end else begin
					reply_want = expected_replies.pop_front();
					compare_field("bus_command", reply_want.cmd, result_bus.bus_command);
					compare_field("load_tx", reply_want.load, result_bus.load_tx);
					compare_field("tx_byte", reply_want.tx, result_bus.tx_byte);
					compare_field("temp_valid", reply_want.tvalid, result_bus.temp_valid);
					compare_field("temperature", reply_want.temp, result_bus.temperature);
					compare_field("sensor_index", reply_want.idx, result_bus.sensor_index);
					compare_field("divide_fault", reply_want.fault, result_bus.divide_fault);
					compare_field("round_done", reply_want.wrap, result_bus.round_done);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				stall_left = next_gap();
			end
		end
	end

	initial begin
		int         p;
		int         k;
		int         start;
		logic [7:0] top_w;
		logic [7:0] limit_w;
		mismatches = 0;
		polls_queued = 0;
		idle_on = 1'b1;
		noise_pct = 20;
		top_plan = '{8'hF8, 8'hFF, 8'h01, 8'h00, 8'h07, 8'h00, 8'h00, 8'h02};
		limit_plan = '{8'd254, 8'd1, 8'd255, 8'd0, 8'd30, 8'd0, 8'd0, 8'd2};

		push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
		push_poll(ACT_TICK, 1'b1, 1'b1, 8'hFF, 8'hFF);
		push_poll(ACT_POLL, 1'b0, 1'b1, 8'hFF, 8'hFF);
		push_poll(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b0, 8'hFF, 8'h00);
		push_poll(ACT_POLL, 1'b0, 1'b1, 8'h00, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b0, 8'h00, 8'hFF);
		push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b0, ST_START | 8'h07, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b1, 8'h00, 8'h00);
		push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
		for (k = 0; k < 4; k++) begin
			push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
			push_poll(ACT_POLL, 1'b1, 1'b0, ST_ADDR_W_OK, 8'h00);
			push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
		end
		push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b0, ST_RESTART, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b0, ST_ADDR_R_OK, 8'h00);
		push_poll(ACT_POLL, 1'b1, 1'b0, 8'h00, 8'h00);
		push_poll(ACT_POLL, 1'b0, 1'b0, 8'h00, 8'h00);

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (p = 0; p < 8; p++) begin
			wait_idle();
			repeat (40) @(negedge clk);
			top_w = top_plan[p];
			limit_w = limit_plan[p];
			if (p == 5 || p == 6) begin
				top_w = rbyte();
				limit_w = 8'($urandom_range(1, 254));
			end
			write_reg(REG_TOP_SENSOR, top_w);
			write_reg(REG_TIMEOUT_LIMIT, limit_w);
			do @(negedge clk);
			while (pending_writes.size() != 0 || cfg_bus.valid);
			idle_on = (p != 4);
			noise_pct = $urandom_range(5, 40);
			start = polls_queued;
			if (limit_w == TIMEOUT_SAT) begin
				push_poll(ACT_POLL, 1'b0, 1'b1, rbyte(), rbyte());
				push_poll(ACT_POLL, 1'b0, 1'b1, rbyte(), rbyte());
				repeat (260) push_poll(ACT_TICK, rbit(), rbit(), rbyte(), rbyte());
				push_poll(ACT_POLL, 1'b0, 1'b1, rbyte(), rbyte());
			end
			while (polls_queued - start < 180) begin
				if ($urandom_range(0, 9) == 0) begin
					k = $urandom_range(1, 5);
					repeat (k) push_poll(rbit(), rbit(), rbit(), rbyte(), rbyte());
				end else begin
					poll_sensor();
				end
			end
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
